// File: hdl/gtsf_pkg.sv
// ----------------------------------------------------------------------------
// gtsf_pkg
// Shared types and constants of the generation-tagged sample FIFO.
// ----------------------------------------------------------------------------
package gtsf_pkg;

  localparam int DEPTH       = 1024;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = 11;
  localparam int MAX_POP     = 32;
  localparam int POP_W       = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QD_W        = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_DISCARD = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  localparam logic [1:0] RES_SAMPLE  = 2'd0;
  localparam logic [1:0] RES_STATUS  = 2'd1;
  localparam logic [1:0] RES_SUMMARY = 2'd2;
  localparam logic [1:0] RES_DROPPED = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      sample;
    logic [63:0]      generation;
    logic [CNT_W-1:0] blen;
    logic [POP_W-1:0] pop_lim;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      sample;
    logic             accepted;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] skipped;
    logic             last;
  } res_t;

endpackage

// File: hdl/gtsf_front.sv
// ----------------------------------------------------------------------------
// gtsf_front
// Accepts requests, drops unknown ones and normalizes burst and pop limits.
// ----------------------------------------------------------------------------
module gtsf_front import gtsf_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [31:0]       sample_bits,
  input  logic [63:0]       generation,
  input  logic [CNT_W-1:0]  burst_len,
  input  logic [POP_W-1:0]  pop_max,
  output logic              q_push,
  input  logic              q_ready,
  output cmd_t              q_cmd
);

  logic known;

  always_comb begin
    unique case (req_type)
      REQ_PUSH, REQ_POP, REQ_DISCARD: known = 1'b1;
      default:                        known = 1'b0;
    endcase
  end

  assign in_stall = !q_ready;
  assign q_push   = in_valid && q_ready && known;

  always_comb begin
    q_cmd.kind       = req_type;
    q_cmd.sample     = sample_bits;
    q_cmd.generation = generation;
    q_cmd.blen       = (burst_len == '0) ? CNT_W'(1) : burst_len;
    q_cmd.pop_lim    = (pop_max > POP_W'(MAX_POP)) ? POP_W'(MAX_POP) : pop_max;
  end

endmodule

// File: hdl/gtsf_queue.sv
// ----------------------------------------------------------------------------
// gtsf_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module gtsf_queue import gtsf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  output logic q_valid,
  input  logic pop,
  output cmd_t q_cmd
);

  cmd_t            slots [QUEUE_DEPTH];
  logic [QD_W-1:0] wr_ptr;
  logic [QD_W-1:0] rd_ptr;
  logic [QD_W:0]   fill;
  logic            do_pop;

  assign ready   = fill != (QD_W+1)'(QUEUE_DEPTH);
  assign q_valid = fill != '0;
  assign q_cmd   = slots[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QD_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QD_W'(1);
      end
      if (push && !do_pop) begin
        fill <= fill + (QD_W+1)'(1);
      end else if (!push && do_pop) begin
        fill <= fill - (QD_W+1)'(1);
      end
    end
  end

endmodule

// File: hdl/gtsf_back.sv
// ----------------------------------------------------------------------------
// gtsf_back
// Executes push, pop and discard against the sample and tag memories and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module gtsf_back import gtsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             q_valid,
  output logic             q_ready,
  input  cmd_t             q_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output res_t             res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SUM   = 2'd2;

  logic [31:0]       mem_sample [DEPTH];
  logic [63:0]       mem_tag    [DEPTH];
  logic [31:0]       rd_sample;
  logic [63:0]       rd_tag;
  logic [ADDR_W-1:0] rd_addr;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [CNT_W-1:0]  cap;
  logic [ADDR_W-1:0] rp;
  logic [ADDR_W-1:0] wp;
  logic [CNT_W-1:0]  fill_level;
  logic [CNT_W-1:0]  burst_rem;
  logic              burst_ok;
  logic [63:0]       pop_gen;
  logic [POP_W-1:0]  pop_lim;
  logic [POP_W-1:0]  copied;
  logic [CNT_W-1:0]  skipped;

  logic              out_free;
  logic              take;
  logic              emit;
  res_t              emit_res;
  logic [ADDR_W-1:0] rp_inc;
  logic [ADDR_W-1:0] wp_inc;
  logic [CNT_W-1:0]  rem_eff;
  logic              ok_eff;
  logic              wr_en;
  logic              match;
  logic              advance;
  logic [POP_W-1:0]  copied_next;
  logic [CNT_W-1:0]  cap_clamped;

  assign out_free = !out_valid || !out_stall;
  assign q_ready  = (state == ST_IDLE) && out_free;
  assign take     = q_valid && q_ready;

  assign rp_inc = (({1'b0, rp} + CNT_W'(1)) >= cap) ? '0 : rp + ADDR_W'(1);
  assign wp_inc = (({1'b0, wp} + CNT_W'(1)) >= cap) ? '0 : wp + ADDR_W'(1);

  assign rem_eff = (burst_rem == '0) ? q_cmd.blen : burst_rem;
  assign ok_eff  = (burst_rem == '0)
                 ? ((fill_level <= cap) && (q_cmd.blen <= cap - fill_level))
                 : burst_ok;
  assign wr_en   = take && (q_cmd.kind == REQ_PUSH) && ok_eff;

  assign match       = rd_tag == pop_gen;
  assign advance     = (state == ST_CHECK) && (!match || out_free);
  assign copied_next = copied + POP_W'(match);
  assign rd_addr     = advance ? rp_inc : rp;

  always_comb begin
    if (cfg_data == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (cfg_data > CNT_W'(DEPTH)) begin
      cap_clamped = CNT_W'(DEPTH);
    end else begin
      cap_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_sample[wp] <= q_cmd.sample;
      mem_tag[wp]    <= q_cmd.generation;
    end
    rd_sample <= mem_sample[rd_addr];
    rd_tag    <= mem_tag[rd_addr];
  end

  always_comb begin
    emit       = 1'b0;
    emit_res   = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          case (q_cmd.kind)
            REQ_PUSH: begin
              if (rem_eff == CNT_W'(1)) begin
                emit              = 1'b1;
                emit_res.kind     = RES_STATUS;
                emit_res.accepted = ok_eff;
                emit_res.last     = 1'b1;
              end
            end
            REQ_POP: begin
              if (fill_level != '0 && q_cmd.pop_lim != '0) begin
                state_next = ST_CHECK;
              end else begin
                state_next = ST_SUM;
              end
            end
            default: begin
              emit           = 1'b1;
              emit_res.kind  = RES_DROPPED;
              emit_res.count = fill_level;
              emit_res.last  = 1'b1;
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (advance) begin
          if (match) begin
            emit            = 1'b1;
            emit_res.kind   = RES_SAMPLE;
            emit_res.sample = rd_sample;
          end
          if (fill_level == CNT_W'(1) || copied_next >= pop_lim) begin
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_res.kind    = RES_SUMMARY;
          emit_res.count   = {{(CNT_W-POP_W){1'b0}}, copied};
          emit_res.skipped = skipped;
          emit_res.last    = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cap        <= CNT_W'(DEPTH);
      rp         <= '0;
      wp         <= '0;
      fill_level <= '0;
      burst_rem  <= '0;
      burst_ok   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        cap        <= cap_clamped;
        rp         <= '0;
        wp         <= '0;
        fill_level <= '0;
        burst_rem  <= '0;
        burst_ok   <= 1'b0;
      end else if (take && q_cmd.kind == REQ_PUSH) begin
        if (ok_eff) begin
          wp <= wp_inc;
          if (fill_level < cap) begin
            fill_level <= fill_level + CNT_W'(1);
          end
        end
        burst_rem <= rem_eff - CNT_W'(1);
        burst_ok  <= (rem_eff == CNT_W'(1)) ? 1'b0 : ok_eff;
      end else if (take && q_cmd.kind == REQ_DISCARD) begin
        rp         <= wp;
        fill_level <= '0;
      end else if (advance) begin
        rp         <= rp_inc;
        fill_level <= fill_level - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_res;
    end
    if (take) begin
      pop_gen <= q_cmd.generation;
      pop_lim <= q_cmd.pop_lim;
      copied  <= '0;
      skipped <= '0;
    end else if (advance) begin
      copied <= copied_next;
      if (!match) begin
        skipped <= skipped + CNT_W'(1);
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= cap) else $error("fill level above capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, rp} < cap) && ({1'b0, wp} < cap)) else $error("pointer beyond capacity");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> fill_level != '0) else $error("walking an empty FIFO");

  a_walk_limit: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> copied < pop_lim) else $error("pop limit overrun");

  a_burst_flag: assert property (@(posedge clk) disable iff (rst)
    burst_rem == '0 |-> !burst_ok) else $error("space flag set with no open burst");

endmodule

// File: hdl/generation_tagged_sample_fifo_unit.sv
// ----------------------------------------------------------------------------
// generation_tagged_sample_fifo_unit
// Circular sample FIFO with generation tags, all-or-nothing push bursts and
// tag-filtered pops.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// request   in         in_valid / in_stall   req_type .. pop_max
// result    out        out_valid / out_stall result_kind .. last
// capacity  in         cfg_we                cfg_data
//
// A push or discard is taken in the back end's idle state; pushes sustain one
// per cycle. A pop walks entries through the registered read port, one per
// cycle, then emits a summary. A 4-entry command queue decouples the request
// side from the back end. Reset (rst, synchronous) empties the FIFO and sets
// capacity to 1024; memory contents are not cleared. A stalled result holds
// the back end (a walk only at a match); requests flow until the queue fills.
// ----------------------------------------------------------------------------
module generation_tagged_sample_fifo_unit import gtsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       req_type,
  input  logic [31:0]      sample_bits,
  input  logic [63:0]      generation,
  input  logic [CNT_W-1:0] burst_len,
  input  logic [POP_W-1:0] pop_max,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       result_kind,
  output logic [31:0]      out_sample,
  output logic             accepted,
  output logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0] skipped_count,
  output logic             last
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_push;
  logic queue_ready;
  logic queue_valid;
  logic back_ready;
  res_t res;

  gtsf_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .sample_bits (sample_bits),
    .generation  (generation),
    .burst_len   (burst_len),
    .pop_max     (pop_max),
    .q_push      (front_push),
    .q_ready     (queue_ready),
    .q_cmd       (front_cmd)
  );

  gtsf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_cmd (front_cmd),
    .ready    (queue_ready),
    .q_valid  (queue_valid),
    .pop      (back_ready),
    .q_cmd    (queue_cmd)
  );

  gtsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (queue_valid),
    .q_ready   (back_ready),
    .q_cmd     (queue_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign result_kind   = res.kind;
  assign out_sample    = res.sample;
  assign accepted      = res.accepted;
  assign count         = res.count;
  assign skipped_count = res.skipped;
  assign last          = res.last;

endmodule

// File: tb/tb_generation_tagged_sample_fifo_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_generation_tagged_sample_fifo_unit
// Self-checking bench for the generation-tagged sample FIFO. A directed table
// covers empty pops, discards, zero and saturated limits, bursts split by pops
// and discards, rejected bursts and capacity extremes. Random phases then mix
// bursts, tag-filtered pops, discards and ignored requests over several
// capacities and idling patterns. Every result transfer is compared with a
// cycle-free prediction of the FIFO.
// ----------------------------------------------------------------------------
module tb_generation_tagged_sample_fifo_unit;
  import gtsf_pkg::*;

  localparam int LIMIT        = 600000;
  localparam int SETTLE       = 64;
  localparam int RANDOM_ITEMS = 460;
  localparam int N_PHASES     = 6;
  localparam logic [63:0] GEN_ZERO = 64'h0;
  localparam logic [63:0] GEN_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] GEN_A    = 64'h0123_4567_89AB_CDEF;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [1:0]       req;
    logic [31:0]      sample;
    logic [63:0]      gen;
    logic [CNT_W-1:0] blen;
    logic [POP_W-1:0] pmax;
    logic             typed;
    res_t             res;
  } stim_row_t;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             cfg_we        = 1'b0;
  logic [CNT_W-1:0] cfg_data      = '0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic [1:0]       req_type      = REQ_NONE;
  logic [31:0]      sample_bits   = '0;
  logic [63:0]      generation    = '0;
  logic [CNT_W-1:0] burst_len     = '0;
  logic [POP_W-1:0] pop_max       = '0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [1:0]       result_kind;
  logic [31:0]      out_sample;
  logic             accepted;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] skipped_count;
  logic             last;

  // typed expectation travelling with the current request
  logic             item_typed    = 1'b0;
  res_t             item_res      = '0;

  // predicted FIFO state
  logic [31:0]      sample_mem [DEPTH];
  logic [63:0]      tag_mem [DEPTH];
  int               rd_ptr, wr_ptr, fill, burst_left;
  bit               burst_good;
  logic [CNT_W-1:0] cap_reg;

  res_t             due_results [$];
  stim_row_t        dir_rows [$];
  logic [63:0]      gen_pool [4];
  int               mismatches  = 0;
  int               cycles      = 0;
  int               send_pct    = 0;
  int               stall_pct   = 0;
  int               random_sent = 0;

  generation_tagged_sample_fifo_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .sample_bits   (sample_bits),
    .generation    (generation),
    .burst_len     (burst_len),
    .pop_max       (pop_max),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .out_sample    (out_sample),
    .accepted      (accepted),
    .count         (count),
    .skipped_count (skipped_count),
    .last          (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic predict_results(input logic [1:0] rq, input logic [31:0] smp,
                                 input logic [63:0] gen, input logic [CNT_W-1:0] blen,
                                 input logic [POP_W-1:0] pmax, input logic typed,
                                 input res_t typed_res);
    int   eff_cap;
    int   lim;
    int   n_copy;
    int   n_skip;
    res_t r;
    eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
    n_copy  = 0;
    n_skip  = 0;
    r       = '0;
    case (rq)
      REQ_PUSH: begin
        if (burst_left == 0) begin
          burst_left = (blen == 0) ? 1 : int'(blen);
          burst_good = (fill <= eff_cap) && (burst_left <= eff_cap - fill);
        end
        if (burst_good) begin
          sample_mem[wr_ptr] = smp;
          tag_mem[wr_ptr]    = gen;
          wr_ptr = (wr_ptr + 1 >= eff_cap) ? 0 : wr_ptr + 1;
          if (fill < eff_cap) fill++;
        end
        burst_left--;
        if (burst_left == 0) begin
          r.kind     = RES_STATUS;
          r.accepted = burst_good;
          r.last     = 1'b1;
          if (typed) r = typed_res;
          due_results.push_back(r);
          burst_good = 1'b0;
        end
      end
      REQ_POP: begin
        lim = (pmax > MAX_POP) ? MAX_POP : int'(pmax);
        while (fill > 0 && n_copy < lim) begin
          if (tag_mem[rd_ptr] == gen) begin
            r        = '0;
            r.kind   = RES_SAMPLE;
            r.sample = sample_mem[rd_ptr];
            due_results.push_back(r);
            n_copy++;
          end else begin
            n_skip++;
          end
          rd_ptr = (rd_ptr + 1 >= eff_cap) ? 0 : rd_ptr + 1;
          fill--;
        end
        r         = '0;
        r.kind    = RES_SUMMARY;
        r.count   = CNT_W'(n_copy);
        r.skipped = CNT_W'(n_skip);
        r.last    = 1'b1;
        if (typed) r = typed_res;
        due_results.push_back(r);
      end
      REQ_DISCARD: begin
        r.kind  = RES_DROPPED;
        r.count = CNT_W'(fill);
        r.last  = 1'b1;
        rd_ptr  = wr_ptr;
        fill    = 0;
        if (typed) r = typed_res;
        due_results.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (rst) begin
      rd_ptr     = 0;
      wr_ptr     = 0;
      fill       = 0;
      burst_left = 0;
      burst_good = 1'b0;
      cap_reg    = CNT_W'(DEPTH);
      due_results.delete();
    end else begin
      if (cfg_we) begin
        cap_reg    = cfg_data;
        rd_ptr     = 0;
        wr_ptr     = 0;
        fill       = 0;
        burst_left = 0;
        burst_good = 1'b0;
      end
      if (in_valid && !in_stall) begin
        predict_results(req_type, sample_bits, generation, burst_len, pop_max,
                        item_typed, item_res);
      end
      if (out_valid && !out_stall) begin
        got.kind     = result_kind;
        got.sample   = out_sample;
        got.accepted = accepted;
        got.count    = count;
        got.skipped  = skipped_count;
        got.last     = last;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: kind %0d sample %h acc %0d cnt %0d skip %0d last %0d",
                     got.kind, got.sample, got.accepted, got.count, got.skipped, got.last);
          end
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.sample !== want.sample ||
              got.accepted !== want.accepted || got.count !== want.count ||
              got.skipped !== want.skipped || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: kind %0d sample %h acc %0d cnt %0d skip %0d last %0d",
                       want.kind, want.sample, want.accepted, want.count, want.skipped,
                       want.last);
              $display("         act: kind %0d sample %h acc %0d cnt %0d skip %0d last %0d",
                       got.kind, got.sample, got.accepted, got.count, got.skipped, got.last);
            end
          end
        end
      end
    end
  end

  function automatic stim_row_t mk_row(row_kind_t k, logic [1:0] rq, logic [31:0] smp,
                                       logic [63:0] gen, logic [CNT_W-1:0] blen,
                                       logic [POP_W-1:0] pmax, logic typed,
                                       logic [1:0] ekind, logic eacc,
                                       logic [CNT_W-1:0] ecnt);
    stim_row_t row;
    row              = '0;
    row.kind         = k;
    row.req          = rq;
    row.sample       = smp;
    row.gen          = gen;
    row.blen         = blen;
    row.pmax         = pmax;
    row.typed        = typed;
    row.res.kind     = ekind;
    row.res.accepted = eacc;
    row.res.count    = ecnt;
    row.res.last     = typed;
    return row;
  endfunction

  function automatic logic [63:0] pick_gen();
    if ($urandom_range(99) < 85) return gen_pool[$urandom_range(3)];
    return {$urandom(), $urandom()};
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_pct = 0;  stall_pct = 0;  end
      1: begin send_pct = 76; stall_pct = 0;  end
      2: begin send_pct = 0;  stall_pct = 76; end
      default: begin send_pct = 17; stall_pct = 17; end
    endcase
  endtask

  task automatic send_item(input logic [1:0] rq, input logic [31:0] smp,
                           input logic [63:0] gen, input logic [CNT_W-1:0] blen,
                           input logic [POP_W-1:0] pmax, input logic typed,
                           input res_t tres);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= rq;
    sample_bits <= smp;
    generation  <= gen;
    burst_len   <= blen;
    pop_max     <= pmax;
    item_typed  <= typed;
    item_res    <= tres;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_pop();
    logic [POP_W-1:0] lim;
    lim = ($urandom_range(99) < 30) ? POP_W'($urandom_range(63))
                                     : POP_W'($urandom_range(12));
    send_item(REQ_POP, $urandom(), pick_gen(), CNT_W'($urandom_range(2047)), lim,
              1'b0, '0);
    random_sent++;
  endtask

  // hold the request side until every result is back and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    stim_row_t        row;
    logic [63:0]      burst_gen;
    logic [CNT_W-1:0] first_blen;
    int               len;
    int               big;
    int               cap;
    int               quota;
    int               pick;

    dir_rows.push_back(mk_row(ROW_ITEM, REQ_DISCARD, 32'h0, GEN_ZERO, 11'd0, 6'd0,
                              1'b1, RES_DROPPED, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_POP, 32'h0, GEN_ZERO, 11'd0, 6'd5,
                              1'b1, RES_SUMMARY, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_NONE, 32'hFFFF_FFFF, GEN_ONES, 11'd2047, 6'd63,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'hFFFF_FFFF, GEN_ONES, 11'd0, 6'd63,
                              1'b1, RES_STATUS, 1'b1, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h0000_0000, GEN_ZERO, 11'd3, 6'd0,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h7F80_0000, GEN_ZERO, 11'd2047, 6'd63,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h8000_0000, GEN_ZERO, 11'd0, 6'd0,
                              1'b1, RES_STATUS, 1'b1, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_POP, 32'h0, GEN_ZERO, 11'd0, 6'd0,
                              1'b1, RES_SUMMARY, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_POP, 32'h0, GEN_ZERO, 11'd0, 6'd63,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h3F80_0000, GEN_A, 11'd2, 6'd0,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_POP, 32'h0, GEN_A, 11'd0, 6'd1,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'hBF80_0000, GEN_A, 11'd0, 6'd0,
                              1'b1, RES_STATUS, 1'b1, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h0000_1234, GEN_ONES, 11'd1, 6'd0,
                              1'b1, RES_STATUS, 1'b1, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h0000_0001, GEN_A, 11'd2, 6'd0,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_DISCARD, 32'h0, GEN_ZERO, 11'd0, 6'd0,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h0000_0002, GEN_A, 11'd0, 6'd0,
                              1'b1, RES_STATUS, 1'b1, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_POP, 32'h0, GEN_A, 11'd0, 6'd32,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_CFG, REQ_NONE, 32'h0, GEN_ZERO, 11'd0, 6'd0,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h0000_0005, GEN_ZERO, 11'd1, 6'd0,
                              1'b1, RES_STATUS, 1'b1, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h0000_0006, GEN_ZERO, 11'd1, 6'd0,
                              1'b1, RES_STATUS, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h0000_0007, GEN_ZERO, 11'd2, 6'd0,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h0000_0008, GEN_ZERO, 11'd0, 6'd0,
                              1'b1, RES_STATUS, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_POP, 32'h0, GEN_ZERO, 11'd0, 6'd40,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_PUSH, 32'h0000_0009, GEN_ONES, 11'd1, 6'd0,
                              1'b1, RES_STATUS, 1'b1, 11'd0));
    dir_rows.push_back(mk_row(ROW_CFG, REQ_NONE, 32'h0, GEN_ZERO, 11'd2047, 6'd0,
                              1'b0, RES_SAMPLE, 1'b0, 11'd0));
    dir_rows.push_back(mk_row(ROW_ITEM, REQ_POP, 32'h0, GEN_ONES, 11'd0, 6'd63,
                              1'b1, RES_SUMMARY, 1'b0, 11'd0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_idling(3);
    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        write_capacity(row.blen);
      end else begin
        send_item(row.req, row.sample, row.gen, row.blen, row.pmax, row.typed, row.res);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: cap = 12;
        1: cap = 1024;
        2: cap = 1;
        3: cap = 37;
        4: cap = 3;
        default: cap = 200;
      endcase
      write_capacity(CNT_W'(cap));
      set_idling(p % 4);
      gen_pool[0] = {$urandom(), $urandom()};
      gen_pool[1] = {$urandom(), $urandom()};
      gen_pool[2] = (p % 2 == 0) ? GEN_ONES : GEN_ZERO;
      gen_pool[3] = gen_pool[0] ^ (64'h1 << $urandom_range(63));
      big   = (cap <= 40) ? cap + 3 : 40;
      quota = RANDOM_ITEMS * (p + 1) / N_PHASES;
      while (random_sent < quota) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          len        = ($urandom_range(9) == 0) ? $urandom_range(big, 1) : $urandom_range(6, 1);
          first_blen = (len == 1 && $urandom_range(3) == 0) ? 11'd0 : CNT_W'(len);
          burst_gen  = pick_gen();
          for (int i = 0; i < len; i++) begin
            send_item(REQ_PUSH, $urandom(),
                      ($urandom_range(99) < 80) ? burst_gen : pick_gen(),
                      (i == 0) ? first_blen : CNT_W'($urandom_range(2047)),
                      POP_W'($urandom_range(63)), 1'b0, '0);
            random_sent++;
            if (i != len - 1 && $urandom_range(99) < 8) begin
              if ($urandom_range(1) == 0) begin
                send_random_pop();
              end else begin
                send_item(REQ_DISCARD, $urandom(), pick_gen(),
                          CNT_W'($urandom_range(2047)), POP_W'($urandom_range(63)),
                          1'b0, '0);
                random_sent++;
              end
            end
          end
        end else if (pick < 80) begin
          send_random_pop();
        end else if (pick < 90) begin
          send_item(REQ_DISCARD, $urandom(), pick_gen(), CNT_W'($urandom_range(2047)),
                    POP_W'($urandom_range(63)), 1'b0, '0);
          random_sent++;
        end else begin
          send_item(REQ_NONE, $urandom(), pick_gen(), CNT_W'($urandom_range(2047)),
                    POP_W'($urandom_range(63)), 1'b0, '0);
          random_sent++;
        end
      end
    end

    drain();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/gtsf_pkg.sv
hdl/gtsf_front.sv
hdl/gtsf_queue.sv
hdl/gtsf_back.sv
hdl/generation_tagged_sample_fifo_unit.sv
tb/tb_generation_tagged_sample_fifo_unit.sv
